// ===== src/genomic_interval_stab_query_top_assert.svh =====
// Assertion macros for the genomic interval stabbing query block.
// Included by modules that check their own logic; depends on nothing else.
`ifndef GENOMIC_INTERVAL_STAB_QUERY_TOP_ASSERT_SVH
`define GENOMIC_INTERVAL_STAB_QUERY_TOP_ASSERT_SVH
`ifndef NO_ASSERTIONS
// Same-cycle property, disabled while in reset.
`define GISQ_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
// Antecedent in one cycle, consequent in the next.
`define GISQ_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);
`else
`define GISQ_ASSERT(lbl, clk, rstn, prop, msg)
`define GISQ_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg)
`endif
`endif

// ===== src/gisq_pkg.sv =====
// Package for the genomic interval stabbing query block: sizes, codes, word types.
// Depends on nothing; used by every module of the block.
`default_nettype none

package gisq_pkg;

  localparam int MAX_GENES = 1024;
  localparam int MAX_HITS  = 64;

  localparam int IDX_W  = (MAX_GENES > 1) ? $clog2(MAX_GENES) : 1;
  localparam int CNT_W  = $clog2(MAX_GENES + 1);
  localparam int HIT_W  = $clog2(MAX_HITS + 1);
  localparam int TYPE_W = 2;
  localparam int CHR_W  = 8;
  localparam int POS_W  = 31;
  localparam int STAT_W = 2;
  localparam int GENE_W = 11;

  localparam logic [TYPE_W-1:0] REQ_CLEAR = 2'd0;
  localparam logic [TYPE_W-1:0] REQ_LOAD  = 2'd1;
  localparam logic [TYPE_W-1:0] REQ_QUERY = 2'd2;

  localparam logic [STAT_W-1:0] STAT_ACK     = 2'd0;
  localparam logic [STAT_W-1:0] STAT_MATCH   = 2'd1;
  localparam logic [STAT_W-1:0] STAT_NOMATCH = 2'd2;
  localparam logic [STAT_W-1:0] STAT_FULL    = 2'd3;

  typedef struct packed {
    logic [TYPE_W-1:0] req_type;
    logic [CHR_W-1:0]  chromosome;
    logic [POS_W-1:0]  position;
    logic [POS_W-1:0]  end_position;
  } req_t;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [GENE_W-1:0] gene_number;
    logic              last;
    logic              truncated;
  } rsp_t;

  typedef struct packed {
    logic [CHR_W-1:0] chromosome;
    logic [POS_W-1:0] begin_pos;
    logic [POS_W-1:0] end_pos;
  } entry_t;

  typedef struct packed {
    logic              vld;
    logic [GENE_W-1:0] gene;
  } hit_t;

  typedef struct packed {
    logic              push;
    logic              drain;
    logic [GENE_W-1:0] gene;
  } chain_ctrl_t;

endpackage

`default_nettype wire

// ===== src/gisq_table.sv =====
// Gene interval table: one write port, one registered read port.
// Depends on gisq_pkg.
`default_nettype none

module gisq_table (
  input  wire                        clk_i,
  input  wire                        we_i,
  input  wire  [gisq_pkg::IDX_W-1:0] waddr_i,
  input  gisq_pkg::entry_t           wdata_i,
  input  wire                        re_i,
  input  wire  [gisq_pkg::IDX_W-1:0] raddr_i,
  output gisq_pkg::entry_t           rdata_o
);
  import gisq_pkg::*;

  entry_t mem_q [MAX_GENES];
  entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ===== src/gisq_hit_cell.sv =====
// One cell of the hit chain: holds a gene number and its valid bit.
// Depends on gisq_pkg.
`default_nettype none

module gisq_hit_cell (
  input  wire             clk_i,
  input  wire             rst_ni,
  input  wire             shift_i,
  input  gisq_pkg::hit_t  hit_i,
  output gisq_pkg::hit_t  hit_o
);
  import gisq_pkg::*;

  logic              vld_q;
  logic [GENE_W-1:0] gene_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (shift_i) begin
      vld_q <= hit_i.vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (shift_i) begin
      gene_q <= hit_i.gene;
    end
  end

  assign hit_o.vld  = vld_q;
  assign hit_o.gene = gene_q;

endmodule

`default_nettype wire

// ===== src/gisq_hit_chain.sv =====
// Row of hit cells; a push or a drain step advances every cell by one.
// Depends on gisq_pkg and gisq_hit_cell.
`default_nettype none

module gisq_hit_chain (
  input  wire                   clk_i,
  input  wire                   rst_ni,
  input  gisq_pkg::chain_ctrl_t ctrl_i,
  output gisq_pkg::hit_t        hit_o
);
  import gisq_pkg::*;

  hit_t link [MAX_HITS+1];
  logic shift;

  assign shift        = ctrl_i.push | ctrl_i.drain;
  // Drain steps feed empty cells in at the head.
  assign link[0].vld  = ctrl_i.push;
  assign link[0].gene = ctrl_i.gene;

  for (genvar k = 0; k < MAX_HITS; k++) begin : g_cell
    gisq_hit_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .shift_i (shift),
      .hit_i   (link[k]),
      .hit_o   (link[k+1])
    );
  end

  assign hit_o = link[MAX_HITS];

endmodule

`default_nettype wire

// ===== src/genomic_interval_stab_query_top.sv =====
// Top level of the genomic interval stabbing query block.
// Depends on gisq_pkg, gisq_table, gisq_hit_chain and the assertion header.
//
//   channel   | direction | handshake                  | word
//   ----------+-----------+----------------------------+--------
//   request   | in        | start high, busy low       | req_i
//   result    | out       | rsp_valid_o, one cycle     | rsp_o
//
// Clear and load give a single result word that shows up on the next
// cycle, and busy never rises. A query scans the table one entry per
// cycle through the table read port: busy during the scan, then while
// matches walk down the hit chain (no drain when nothing matched). A
// query on an empty table answers like clear and load. Reset clears the
// entry count and the control state; the table itself is not cleared.
// Results cannot be stalled: each word is shown for one cycle.
`default_nettype none

module genomic_interval_stab_query_top (
  input  wire            clk_i,
  input  wire            rst_ni,
  input  wire            start,
  output logic           busy,
  input  gisq_pkg::req_t req_i,
  output logic           rsp_valid_o,
  output gisq_pkg::rsp_t rsp_o
);
  import gisq_pkg::*;

`include "genomic_interval_stab_query_top_assert.svh"

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_SCAN  = 2'd1;
  localparam logic [1:0] ST_DRAIN = 2'd2;

  logic [1:0]       state_q, state_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic [IDX_W-1:0] idx_q, idx_d;
  logic             issue_q, issue_d;
  logic             cmp_vld_q, cmp_vld_d;
  logic [IDX_W-1:0] tag_q;
  logic [CHR_W-1:0] key_chr_q;
  logic [POS_W-1:0] key_pos_q;
  logic [HIT_W-1:0] hits_q, hits_d;
  logic             trunc_q, trunc_d;
  logic [HIT_W-1:0] emit_q, emit_d;
  logic             rsp_valid_q, rsp_valid_d;
  rsp_t             rsp_q, rsp_d;

  logic             accept;
  logic             we;
  logic             re;
  entry_t           wdata;
  entry_t           rdata;
  logic [IDX_W-1:0] last_tag;
  logic             hit;
  logic             scan_end;
  logic             emit_last;
  chain_ctrl_t      chain_ctrl;
  hit_t             chain_out;

  assign busy     = (state_q != ST_IDLE);
  assign accept   = start && !busy;
  assign last_tag = IDX_W'(count_q - CNT_W'(1));

  assign wdata.chromosome = req_i.chromosome;
  assign wdata.begin_pos  = req_i.position;
  assign wdata.end_pos    = req_i.end_position;

  gisq_table u_table (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (count_q[IDX_W-1:0]),
    .wdata_i (wdata),
    .re_i    (re),
    .raddr_i (idx_q),
    .rdata_o (rdata)
  );

  // Compare the entry read last cycle against the query key.
  assign hit = cmp_vld_q && (rdata.chromosome == key_chr_q) &&
               (rdata.begin_pos <= key_pos_q) && (rdata.end_pos >= key_pos_q);
  assign scan_end = cmp_vld_q && (tag_q == last_tag);

  assign chain_ctrl.push  = hit && (hits_q != HIT_W'(MAX_HITS));
  assign chain_ctrl.drain = (state_q == ST_DRAIN);
  assign chain_ctrl.gene  = GENE_W'(CNT_W'(tag_q) + CNT_W'(1));

  gisq_hit_chain u_chain (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (chain_ctrl),
    .hit_o  (chain_out)
  );

  assign emit_last = (emit_q == HIT_W'(hits_q - HIT_W'(1)));
  assign re        = (state_q == ST_SCAN) && issue_q;

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    idx_d       = idx_q;
    issue_d     = issue_q;
    hits_d      = hits_q;
    trunc_d     = trunc_q;
    emit_d      = emit_q;
    we          = 1'b0;
    cmp_vld_d   = re;
    rsp_valid_d = 1'b0;
    rsp_d       = '0;

    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          case (req_i.req_type)
            REQ_CLEAR: begin
              count_d     = '0;
              rsp_valid_d = 1'b1;
              rsp_d       = '{status: STAT_ACK, gene_number: '0, last: 1'b1,
                              truncated: 1'b0};
            end
            REQ_LOAD: begin
              rsp_valid_d = 1'b1;
              if (count_q == CNT_W'(MAX_GENES)) begin
                rsp_d = '{status: STAT_FULL, gene_number: '0, last: 1'b1,
                          truncated: 1'b0};
              end else begin
                we      = 1'b1;
                count_d = CNT_W'(count_q + CNT_W'(1));
                rsp_d   = '{status: STAT_ACK, gene_number: '0, last: 1'b1,
                            truncated: 1'b0};
              end
            end
            REQ_QUERY: begin
              if (count_q == '0) begin
                rsp_valid_d = 1'b1;
                rsp_d       = '{status: STAT_NOMATCH, gene_number: '0, last: 1'b1,
                                truncated: 1'b0};
              end else begin
                state_d = ST_SCAN;
                idx_d   = '0;
                issue_d = 1'b1;
                hits_d  = '0;
                trunc_d = 1'b0;
                emit_d  = '0;
              end
            end
            default: begin
              // Unused code: drop the word.
            end
          endcase
        end
      end

      ST_SCAN: begin
        // Advance the read address until the last stored entry is issued.
        if (issue_q) begin
          if (idx_q == last_tag) begin
            issue_d = 1'b0;
          end else begin
            idx_d = IDX_W'(idx_q + IDX_W'(1));
          end
        end
        hits_d  = HIT_W'(hits_q + HIT_W'(chain_ctrl.push));
        trunc_d = trunc_q | (hit && !chain_ctrl.push);
        if (scan_end) begin
          if (hits_d == '0) begin
            state_d     = ST_IDLE;
            rsp_valid_d = 1'b1;
            rsp_d       = '{status: STAT_NOMATCH, gene_number: '0, last: 1'b1,
                            truncated: 1'b0};
          end else begin
            state_d = ST_DRAIN;
          end
        end
      end

      ST_DRAIN: begin
        // Matches leave the chain tail in the order they were found.
        if (chain_out.vld) begin
          rsp_valid_d = 1'b1;
          rsp_d       = '{status: STAT_MATCH, gene_number: chain_out.gene,
                          last: emit_last, truncated: trunc_q};
          emit_d      = HIT_W'(emit_q + HIT_W'(1));
          if (emit_last) begin
            state_d = ST_IDLE;
          end
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      idx_q       <= '0;
      issue_q     <= 1'b0;
      cmp_vld_q   <= 1'b0;
      hits_q      <= '0;
      trunc_q     <= 1'b0;
      emit_q      <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      idx_q       <= idx_d;
      issue_q     <= issue_d;
      cmp_vld_q   <= cmp_vld_d;
      hits_q      <= hits_d;
      trunc_q     <= trunc_d;
      emit_q      <= emit_d;
      rsp_valid_q <= rsp_valid_d;
    end
  end

  // Hold the query key, the tag of the entry in flight and the result word.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      key_chr_q <= req_i.chromosome;
      key_pos_q <= req_i.position;
    end
    tag_q <= idx_q;
    rsp_q <= rsp_d;
  end

  assign rsp_valid_o = rsp_valid_q;
  assign rsp_o       = rsp_q;

  // A full chain shows its tail while the scan still runs; only idle must see it empty.
  `GISQ_ASSERT(a_tail_empty_idle, clk_i, rst_ni, chain_out.vld |-> (state_q != ST_IDLE), "hit chain tail valid while idle")
  `GISQ_ASSERT(a_count_in_range, clk_i, rst_ni, count_q <= CNT_W'(MAX_GENES), "entry count beyond table size")
  `GISQ_ASSERT(a_match_numbered, clk_i, rst_ni, (rsp_valid_q && (rsp_q.status == STAT_MATCH)) |-> (rsp_q.gene_number != '0), "match without gene number")
  `GISQ_ASSERT(a_trunc_on_match, clk_i, rst_ni, (rsp_valid_q && rsp_q.truncated) |-> (rsp_q.status == STAT_MATCH), "truncated flag on non-match result")
  `GISQ_ASSERT_NEXT(a_load_counts, clk_i, rst_ni, accept && (req_i.req_type == REQ_LOAD) && (count_q != CNT_W'(MAX_GENES)), count_q == CNT_W'($past(count_q) + CNT_W'(1)), "load did not advance entry count")

endmodule

`default_nettype wire

// ===== tb/sv/tb_genomic_interval_stab_query_top.sv =====
// Self-checking bench for genomic_interval_stab_query_top: a directed table, then random
// load/query sequences and a full-table pass, all scored against an in-bench gene table.
// Depends on gisq_pkg and the RTL of the block; reads no files.
module tb_genomic_interval_stab_query_top;
  timeunit 1ns;
  timeprecision 1ps;

  import gisq_pkg::*;

  // ---------------------------------------------------------------------------
  // Constants
  // ---------------------------------------------------------------------------
  localparam int CLK_HALF   = 5;
  localparam int RST_CYCLES = 9;
  localparam int RAND_ITEMS = 410;
  localparam int PRINT_CAP  = 50;
  // Far above the slowest correct run.
  localparam int TIMEOUT_NS = 8_000_000;
  // Drain wait at the end: a full-table scan plus the hit chain.
  localparam int TAIL_CYCLES = MAX_GENES + MAX_HITS + 16;

  // Request code 3 has no name in the package; the block ignores it.
  localparam logic [TYPE_W-1:0] REQ_UNUSED = 2'd3;
  localparam logic [POS_W-1:0]  POS_MAX    = {POS_W{1'b1}};

  localparam rsp_t RSP_ACK     = '{STAT_ACK,     GENE_W'(0), 1'b1, 1'b0};
  localparam rsp_t RSP_NOMATCH = '{STAT_NOMATCH, GENE_W'(0), 1'b1, 1'b0};
  localparam rsp_t RSP_FULL    = '{STAT_FULL,    GENE_W'(0), 1'b1, 1'b0};

  // Sender idle percentage per phase; the phase advances every eight random sequences and every 256 loads of the fill.
  localparam int IDLE_PHASES [3] = '{0, 81, 27};

  // One row of the directed table. When typed is set, the answer is the single
  // word the block must return; otherwise the gene table predicts it.
  typedef struct packed {
    req_t word;
    logic typed;
    rsp_t answer;
  } dir_row_t;

  localparam int N_DIR = 21;
  localparam dir_row_t DIR_ROWS [N_DIR] = '{
    // query on the empty table
    '{'{REQ_QUERY,  8'd0,   31'd0,   31'd0},   1'b1, RSP_NOMATCH},
    // unused code: no answer at all
    '{'{REQ_UNUSED, 8'd255, POS_MAX, POS_MAX}, 1'b0, '0},
    // genes 1..5, field extremes, one with begin after end (gene 4)
    '{'{REQ_LOAD,   8'd0,   31'd0,   31'd0},   1'b1, RSP_ACK},
    '{'{REQ_LOAD,   8'd255, POS_MAX, POS_MAX}, 1'b1, RSP_ACK},
    '{'{REQ_LOAD,   8'd255, 31'd0,   POS_MAX}, 1'b1, RSP_ACK},
    '{'{REQ_LOAD,   8'd3,   31'd100, 31'd50},  1'b1, RSP_ACK},
    '{'{REQ_LOAD,   8'd3,   31'd50,  31'd100}, 1'b1, RSP_ACK},
    '{'{REQ_QUERY,  8'd0,   31'd0,   POS_MAX}, 1'b0, '0},
    '{'{REQ_QUERY,  8'd255, POS_MAX, 31'd0},   1'b0, '0},
    '{'{REQ_QUERY,  8'd255, 31'd0,   31'd0},   1'b0, '0},
    '{'{REQ_QUERY,  8'd3,   31'd75,  31'd0},   1'b0, '0},
    '{'{REQ_QUERY,  8'd3,   31'd100, 31'd0},   1'b0, '0},
    '{'{REQ_QUERY,  8'd3,   31'd49,  31'd0},   1'b0, '0},
    '{'{REQ_QUERY,  8'd3,   31'd101, 31'd0},   1'b0, '0},
    '{'{REQ_QUERY,  8'd1,   31'd0,   31'd0},   1'b0, '0},
    '{'{REQ_UNUSED, 8'd3,   31'd50,  31'd100}, 1'b0, '0},
    '{'{REQ_QUERY,  8'd3,   31'd50,  31'd0},   1'b0, '0},
    // clear empties the table; the next query finds nothing
    '{'{REQ_CLEAR,  8'd255, POS_MAX, POS_MAX}, 1'b1, RSP_ACK},
    '{'{REQ_QUERY,  8'd255, POS_MAX, POS_MAX}, 1'b1, RSP_NOMATCH},
    '{'{REQ_LOAD,   8'd9,   31'd10,  31'd20},  1'b1, RSP_ACK},
    '{'{REQ_QUERY,  8'd9,   31'd15,  31'd0},   1'b0, '0}
  };

  // ---------------------------------------------------------------------------
  // Clock, reset and DUT
  // ---------------------------------------------------------------------------
  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;
  logic start  = 1'b0;
  logic busy;
  req_t req_i  = '0;
  logic rsp_valid_o;
  rsp_t rsp_o;

  always #CLK_HALF clk_i = ~clk_i;

  genomic_interval_stab_query_top dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .req_i       (req_i),
    .rsp_valid_o (rsp_valid_o),
    .rsp_o       (rsp_o)
  );

  // ---------------------------------------------------------------------------
  // Gene table predictor: its own copy of the entries and the entry count
  // ---------------------------------------------------------------------------
  logic [CHR_W-1:0] gt_chr [MAX_GENES];
  logic [POS_W-1:0] gt_beg [MAX_GENES];
  logic [POS_W-1:0] gt_end [MAX_GENES];
  int               gt_count = 0;

  // Answer words of the latest accepted request.
  rsp_t step_ans [MAX_HITS];
  int   step_n;

  // Answer words still owed by the block, oldest first.
  rsp_t answers_due [$];

  int fail_count = 0;
  int sent_count = 0;
  int idle_pct   = 0;

  // Apply one request to the table and work out the words it must produce.
  task automatic stab_table_step(input req_t w);
    int   hits;
    logic cut;
    hits   = 0;
    cut    = 1'b0;
    step_n = 0;
    case (w.req_type)
      REQ_CLEAR: begin
        gt_count    = 0;
        step_ans[0] = RSP_ACK;
        step_n      = 1;
      end
      REQ_LOAD: begin
        if (gt_count >= MAX_GENES) begin
          step_ans[0] = RSP_FULL;
        end else begin
          gt_chr[gt_count] = w.chromosome;
          gt_beg[gt_count] = w.position;
          gt_end[gt_count] = w.end_position;
          gt_count++;
          step_ans[0] = RSP_ACK;
        end
        step_n = 1;
      end
      REQ_QUERY: begin
        // Scan in load order; a reversed entry can never satisfy both bounds.
        for (int i = 0; i < gt_count; i++) begin
          if (gt_chr[i] == w.chromosome && gt_beg[i] <= w.position &&
              gt_end[i] >= w.position) begin
            if (hits < MAX_HITS) begin
              step_ans[hits] = '{STAT_MATCH, GENE_W'(i + 1), 1'b0, 1'b0};
              hits++;
            end else begin
              cut = 1'b1;
            end
          end
        end
        if (hits == 0) begin
          step_ans[0] = RSP_NOMATCH;
          step_n      = 1;
        end else begin
          step_ans[hits - 1].last = 1'b1;
          for (int k = 0; k < hits; k++) step_ans[k].truncated = cut;
          step_n = hits;
        end
      end
      default: ;  // unused code: drop, nothing changes
    endcase
  endtask

  // ---------------------------------------------------------------------------
  // Mismatch reporting and result scoring
  // ---------------------------------------------------------------------------
  task automatic flag_mismatch(input string what);
    fail_count++;
    // Cap the log on a badly broken block; every mismatch still counts.
    if (fail_count <= PRINT_CAP) $display("[%0t] mismatch: %s", $time, what);
  endtask

  // Results cannot be held off: score every word shown on rsp_valid_o.
  always @(posedge clk_i) begin : score_words
    rsp_t due;
    if (rst_ni && rsp_valid_o === 1'b1) begin
      if (answers_due.size() == 0) begin
        flag_mismatch($sformatf("word with none outstanding: status %0d gene %0d",
                                rsp_o.status, rsp_o.gene_number));
      end else begin
        due = answers_due.pop_front();
        if (rsp_o !== due)
          flag_mismatch($sformatf(
            "status %0d/%0d gene %0d/%0d last %b/%b truncated %b/%b (got/want)",
            rsp_o.status, due.status, rsp_o.gene_number, due.gene_number,
            rsp_o.last, due.last, rsp_o.truncated, due.truncated));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Request driver: change inputs on the falling edge, wait for start && !busy
  // ---------------------------------------------------------------------------
  task automatic issue_word(input req_t w, input logic typed, input rsp_t typed_ans);
    req_t junk;
    @(negedge clk_i);
    // Idle cycles: drop start and scramble the payload while it is low.
    while ($urandom_range(99) < idle_pct) begin
      junk  = {$urandom, $urandom, 8'($urandom)};
      start = 1'b0;
      req_i = junk;
      @(negedge clk_i);
    end
    start = 1'b1;
    req_i = w;
    do @(posedge clk_i); while (busy !== 1'b0);
    // Accepted at this edge: predict now, before any answer can show up.
    stab_table_step(w);
    if (typed) answers_due.push_back(typed_ans);
    else for (int k = 0; k < step_n; k++) answers_due.push_back(step_ans[k]);
    if (w.req_type != REQ_UNUSED) sent_count++;
  endtask

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  function automatic logic [POS_W-1:0] pick_pos();
    int r;
    r = $urandom_range(99);
    if (r < 10)      return '0;
    else if (r < 20) return POS_MAX;
    else if (r < 40) return POS_W'($urandom_range(1000));
    else             return POS_W'($urandom);
  endfunction

  function automatic logic [CHR_W-1:0] pick_chr();
    int r;
    r = $urandom_range(99);
    if (r < 10)      return '0;
    else if (r < 20) return '1;
    else             return CHR_W'($urandom_range(255));
  endfunction

  // Load word: mostly short intervals, some reversed, some in arbitrary order.
  function automatic req_t gene_word(input logic [CHR_W-1:0] c);
    logic [POS_W-1:0] b;
    logic [POS_W-1:0] e;
    logic [POS_W:0]   sum;
    int               r;
    r = $urandom_range(99);
    if (r < 10) begin
      e = POS_W'($urandom_range(1000));
      b = e + 1'b1 + POS_W'($urandom_range(5000));
    end else if (r < 15) begin
      b = pick_pos();
      e = pick_pos();
    end else begin
      b   = pick_pos();
      sum = {1'b0, b} + (POS_W + 1)'($urandom_range(20000));
      e   = sum[POS_W] ? POS_MAX : sum[POS_W-1:0];
    end
    return req_t'{REQ_LOAD, c, b, e};
  endfunction

  function automatic req_t query_word(input logic [CHR_W-1:0] c, input logic [POS_W-1:0] p);
    return req_t'{REQ_QUERY, c, p, POS_W'($urandom)};
  endfunction

  function automatic req_t clear_word();
    return req_t'{REQ_CLEAR, CHR_W'($urandom), POS_W'($urandom), POS_W'($urandom)};
  endfunction

  // Query aimed at a stored entry: its bounds, just outside them, its middle or anywhere.
  task automatic probe_entry();
    int               k;
    logic [POS_W-1:0] p;
    logic [CHR_W-1:0] c;
    if (gt_count == 0) begin
      issue_word(query_word(pick_chr(), pick_pos()), 1'b0, '0);
      return;
    end
    k = $urandom_range(gt_count - 1);
    case ($urandom_range(5))
      0: p = gt_beg[k];
      1: p = gt_end[k];
      2: p = gt_beg[k] - 1'b1;
      3: p = gt_end[k] + 1'b1;
      4: p = (gt_beg[k] <= gt_end[k]) ? gt_beg[k] + (gt_end[k] - gt_beg[k]) / 2 : gt_beg[k];
      default: p = pick_pos();
    endcase
    c = ($urandom_range(9) == 0) ? gt_chr[k] ^ 8'd1 : gt_chr[k];
    issue_word(query_word(c, p), 1'b0, '0);
  endtask

  // Pile wide intervals on one chromosome to hit the MAX_HITS cut-off
  // from just below, exactly at, and above.
  task automatic hit_pile();
    int               n;
    logic [CHR_W-1:0] c;
    case ($urandom_range(3))
      0:       n = MAX_HITS - 1;
      1:       n = MAX_HITS;
      2:       n = MAX_HITS + 1;
      default: n = $urandom_range(MAX_HITS + 26, MAX_HITS + 2);
    endcase
    issue_word(clear_word(), 1'b0, '0);
    c = pick_chr();
    repeat (n) begin
      if ($urandom_range(9) == 0) issue_word(gene_word(c ^ 8'h80), 1'b0, '0);
      issue_word(req_t'{REQ_LOAD, c, POS_W'($urandom_range(1000)),
                        POS_MAX - POS_W'($urandom_range(1000))}, 1'b0, '0);
    end
    issue_word(query_word(c, POS_W'($urandom_range(1_000_000, 2000))), 1'b0, '0);
    issue_word(query_word(c, POS_MAX - POS_W'($urandom_range(1200))), 1'b0, '0);
    probe_entry();
  endtask

  // Clear (usually), load a handful of genes on a few chromosomes, then query.
  task automatic load_and_query();
    logic [CHR_W-1:0] pool [3];
    int               n;
    if (gt_count > 150 || $urandom_range(99) < 70) issue_word(clear_word(), 1'b0, '0);
    for (int i = 0; i < 3; i++) pool[i] = pick_chr();
    n = $urandom_range(24, 1);
    repeat (n) issue_word(gene_word(pool[$urandom_range(2)]), 1'b0, '0);
    n = $urandom_range(8, 2);
    repeat (n) begin
      if ($urandom_range(99) < 80) probe_entry();
      else issue_word(query_word(pool[$urandom_range(2)], pick_pos()), 1'b0, '0);
    end
  endtask

  // Arbitrary words of any code, the unused one included.
  task automatic noise_burst();
    req_t junk;
    if (gt_count > 150) issue_word(clear_word(), 1'b0, '0);
    repeat ($urandom_range(4, 1)) begin
      junk = {$urandom, $urandom, 8'($urandom)};
      issue_word(junk, 1'b0, '0);
    end
  endtask

  // Fill every slot, overfill, and query the full table; the last gene sits
  // alone on chromosome 200 so gene number MAX_GENES shows up on its own.
  task automatic fill_table();
    logic [CHR_W-1:0] c;
    issue_word(clear_word(), 1'b0, '0);
    for (int i = 0; i < MAX_GENES; i++) begin
      idle_pct = IDLE_PHASES[(i / 256) % 3];
      if (i == MAX_GENES - 1) begin
        issue_word(req_t'{REQ_LOAD, 8'd200, 31'd5, 31'd5}, 1'b0, '0);
      end else if ($urandom_range(99) < 70) begin
        issue_word(req_t'{REQ_LOAD, 8'd7, POS_W'($urandom_range(1000)),
                          POS_MAX - POS_W'($urandom_range(1000))}, 1'b0, '0);
      end else begin
        c = pick_chr();
        if (c == 8'd200) c = 8'd201;
        issue_word(gene_word(c), 1'b0, '0);
      end
    end
    repeat (3) issue_word(gene_word(pick_chr()), 1'b0, '0);
    issue_word(query_word(8'd7, POS_W'($urandom_range(1_000_000, 2000))), 1'b0, '0);
    issue_word(query_word(8'd200, 31'd5), 1'b0, '0);
    issue_word(query_word(8'd200, 31'd6), 1'b0, '0);
    repeat (3) probe_entry();
    // Table usable again after a clear.
    issue_word(clear_word(), 1'b0, '0);
    issue_word(query_word(8'd7, 31'd5000), 1'b0, '0);
    issue_word(gene_word(8'd7), 1'b0, '0);
    probe_entry();
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin : run
    int seq;
    int r;
    int rand_goal;
    seq = 0;

    // Hold reset, then release it away from the rising edge.
    repeat (RST_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed table, back to back.
    idle_pct = 0;
    for (int i = 0; i < N_DIR; i++)
      issue_word(DIR_ROWS[i].word, DIR_ROWS[i].typed, DIR_ROWS[i].answer);

    // Random sequences; the idle phase advances every eight sequences.
    rand_goal = sent_count + RAND_ITEMS;
    while (sent_count < rand_goal) begin
      idle_pct = IDLE_PHASES[(seq / 8) % 3];
      r = $urandom_range(99);
      if (r < 8)       noise_burst();
      else if (r < 16) hit_pile();
      else             load_and_query();
      seq++;
    end

    fill_table();

    @(negedge clk_i);
    start = 1'b0;

    // Wait out outstanding answers, then watch for stray words.
    while (answers_due.size() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);

    if (fail_count == 0) begin
      $display("** genomic_interval_stab_query_top: PASSED **");
    end else begin
      $display("** genomic_interval_stab_query_top: FAILED **");
    end
    $finish;
  end

  // Watchdog: a hung handshake or a lost answer ends the run here.
  initial begin : watchdog
    #(TIMEOUT_NS);
    $display("** genomic_interval_stab_query_top: FAILED **");
    $finish;
  end

endmodule

// ===== genomic_interval_stab_query_top.f =====
+incdir+src
src/gisq_pkg.sv
src/gisq_table.sv
src/gisq_hit_cell.sv
src/gisq_hit_chain.sv
src/genomic_interval_stab_query_top.sv
tb/sv/tb_genomic_interval_stab_query_top.sv
